// ===== sv/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies; used by ple_cell, ple_chain and positional_list_engine.
package ple_pkg;

  localparam int DATA_W       = 32;
  localparam int CMD_W        = 3;
  localparam int POS_W        = 5;
  localparam int STAT_W       = 2;
  localparam int CAPACITY_DEF = 16;
  localparam int CAP_MAX      = 64;
  // wide enough for any index or count up to CAP_MAX
  localparam int IDX_W        = $clog2(CAP_MAX + 1);

  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_READOUT   = 3'd6;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_DEL,
    OP_ROT
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;   // insert/delete position
    logic [IDX_W-1:0] tail;  // index of last stored value, for rotate
  } cell_ctl_t;

endpackage

// ===== sv/ple_cell.sv =====
// One storage cell of the list chain: holds one value and takes it from
// its left or right neighbor, the new value or the head. Uses ple_pkg.
module ple_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  ple_pkg::cell_ctl_t         ctl,
  input  logic [ple_pkg::DATA_W-1:0] left_val,
  input  logic [ple_pkg::DATA_W-1:0] right_val,
  input  logic [ple_pkg::DATA_W-1:0] head_val,
  input  logic [ple_pkg::DATA_W-1:0] new_val,
  output logic [ple_pkg::DATA_W-1:0] val
);

  localparam logic [ple_pkg::IDX_W-1:0] ME = ple_pkg::IDX_W'(IDX);

  logic [ple_pkg::DATA_W-1:0] val_r;
  logic [ple_pkg::DATA_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      ple_pkg::OP_INS: begin
        if (ME > ctl.pos) begin
          val_nxt = left_val;
        end else if (ME == ctl.pos) begin
          val_nxt = new_val;
        end
      end
      ple_pkg::OP_DEL: begin
        if (ME >= ctl.pos) begin
          val_nxt = right_val;
        end
      end
      ple_pkg::OP_ROT: begin
        // tail wraps around to the head's value
        if (ME < ctl.tail) begin
          val_nxt = right_val;
        end else if (ME == ctl.tail) begin
          val_nxt = head_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== sv/ple_chain.sv =====
// Row of CAPACITY list cells wired to their neighbors, front at index 0.
// Uses ple_pkg and ple_cell.
module ple_chain #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                       clk,
  input  ple_pkg::cell_ctl_t         ctl,
  input  logic [ple_pkg::DATA_W-1:0] new_val,
  output logic [ple_pkg::DATA_W-1:0] head_val
);

  logic [ple_pkg::DATA_W-1:0] vals [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ple_pkg::DATA_W-1:0] left_val;
    logic [ple_pkg::DATA_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = new_val;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = vals[i];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    ple_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .left_val  (left_val),
      .right_val (right_val),
      .head_val  (vals[0]),
      .new_val   (new_val),
      .val       (vals[i])
    );
  end

  assign head_val = vals[0];

endmodule

// ===== sv/positional_list_engine.sv =====
// Edit commands: one transfer per cycle while the output slot is free; status registered
// in the cycle after transfer. Readout of N values: N results, one per cycle while the
// output slot is free, loaded from S_READ into the output register; the next command is
// taken after the last result is loaded. The rotate pass through the cell chain sets the
// readout rate; it restores list order. Reset (rst_n low, synchronous) empties the list
// and the output register; cell contents are not cleared.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ple_pkg::CMD_W-1:0]         in_command,
  input  logic signed [ple_pkg::DATA_W-1:0] in_value,
  input  logic [ple_pkg::POS_W-1:0]         in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ple_pkg::STAT_W-1:0]        out_status,
  output logic signed [ple_pkg::DATA_W-1:0] out_item_value,
  output logic                              out_last_result
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ple_pkg::STAT_W-1:0]    out_status_r, out_status_nxt;
  logic [ple_pkg::DATA_W-1:0]    out_item_r, out_item_nxt;
  logic                          out_last_r, out_last_nxt;

  ple_pkg::cell_ctl_t            ctl;
  logic [ple_pkg::DATA_W-1:0]    head_val;
  logic                          slot_free;
  logic                          in_xfer;
  logic                          load;
  logic                          is_full;
  logic                          is_empty;
  logic [PW-1:0]                 pos_x;
  logic [PW-1:0]                 cnt_x;
  logic [ple_pkg::IDX_W-1:0]     cnt_i;
  logic [ple_pkg::IDX_W-1:0]     pos_i;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && slot_free;
  assign in_xfer   = in_valid && in_ready;
  assign is_full   = (count_r == CW'(CAPACITY));
  assign is_empty  = (count_r == '0);
  assign pos_x     = PW'(in_position);
  assign cnt_x     = PW'(count_r);
  assign cnt_i     = ple_pkg::IDX_W'(count_r);
  assign pos_i     = ple_pkg::IDX_W'(in_position);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    load           = 1'b0;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_last_nxt   = out_last_r;
    ctl.op         = ple_pkg::OP_HOLD;
    ctl.pos        = '0;
    ctl.tail       = cnt_i - ple_pkg::IDX_W'(1);

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          load           = 1'b1;
          out_status_nxt = ple_pkg::STAT_OK;
          out_item_nxt   = '0;
          out_last_nxt   = 1'b1;
          case (in_command)
            ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_POS, ple_pkg::CMD_INS_BACK: begin
              if (is_full) begin
                out_status_nxt = ple_pkg::STAT_FULL;
              end else if (in_command == ple_pkg::CMD_INS_POS && pos_x > cnt_x) begin
                out_status_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op    = ple_pkg::OP_INS;
                count_nxt = count_r + CW'(1);
                if (in_command == ple_pkg::CMD_INS_POS) begin
                  ctl.pos = pos_i;
                end else if (in_command == ple_pkg::CMD_INS_BACK) begin
                  ctl.pos = cnt_i;
                end
              end
            end
            ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_POS, ple_pkg::CMD_DEL_BACK: begin
              if (is_empty) begin
                out_status_nxt = ple_pkg::STAT_EMPTY;
              end else if (in_command == ple_pkg::CMD_DEL_POS && pos_x >= cnt_x) begin
                out_status_nxt = ple_pkg::STAT_BADPOS;
              end else begin
                ctl.op    = ple_pkg::OP_DEL;
                count_nxt = count_r - CW'(1);
                if (in_command == ple_pkg::CMD_DEL_POS) begin
                  ctl.pos = pos_i;
                end else if (in_command == ple_pkg::CMD_DEL_BACK) begin
                  ctl.pos = cnt_i - ple_pkg::IDX_W'(1);
                end
              end
            end
            ple_pkg::CMD_READOUT: begin
              if (is_empty) begin
                out_status_nxt = ple_pkg::STAT_EMPTY;
              end else begin
                // results come from the rotate pass
                load      = 1'b0;
                rem_nxt   = count_r;
                state_nxt = S_READ;
              end
            end
            default: out_status_nxt = ple_pkg::STAT_OK;
          endcase
        end
      end
      S_READ: begin
        if (slot_free) begin
          // emit the head, rotate it to the tail
          load           = 1'b1;
          out_status_nxt = ple_pkg::STAT_OK;
          out_item_nxt   = head_val;
          out_last_nxt   = (rem_r == CW'(1));
          ctl.op         = ple_pkg::OP_ROT;
          rem_nxt        = rem_r - CW'(1);
          if (rem_r == CW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  ple_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk      (clk),
    .ctl      (ctl),
    .new_val  (in_value),
    .head_val (head_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= out_status_nxt;
      out_item_r   <= out_item_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_item_value  = out_item_r;
  assign out_last_result = out_last_r;

endmodule
